### rtl/csi_matrix_bit_unpacker_core_defines.svh
`ifndef CSI_MATRIX_BIT_UNPACKER_CORE_DEFINES_SVH
`define CSI_MATRIX_BIT_UNPACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define CSI_MBU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at the rising clock edge outside reset.
`define CSI_MBU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csi_mbu_pkg.sv
`timescale 1ns / 1ps

package csi_mbu_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned PartW      = 8;
  localparam int unsigned HeaderBits = 3;
  localparam int unsigned EntryBits  = 16;
  localparam int unsigned BufW       = 23;
  localparam int unsigned HeldW      = 5;
  localparam int unsigned PosW       = 13;
  localparam int unsigned TxW        = 2;
  localparam int unsigned CodeW      = 2;
  localparam int unsigned NumCodes   = 3;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;

  typedef enum logic [2:0] {
    REG_NUM_TX     = 3'd0,
    REG_NUM_RX     = 3'd1,
    REG_NUM_LTF    = 3'd2,
    REG_NUM_TONES  = 3'd3,
    REG_ANT_SEL_ON = 3'd4,
    REG_ANT_CODE_0 = 3'd5,
    REG_ANT_CODE_1 = 3'd6,
    REG_ANT_CODE_2 = 3'd7
  } reg_idx_e;

  // Clamped matrix dimensions and strides, ready for the datapath.
  typedef struct packed {
    logic [1:0]      ntx;
    logic [1:0]      nrx;
    logic [2:0]      nltf;
    logic [7:0]      ntones;
    logic [PosW-1:0] ltf_stride;
    logic [PosW-1:0] tx_stride;
  } geom_t;

endpackage

### rtl/csi_mbu_if.sv
`timescale 1ns / 1ps

interface csi_mbu_in_if;
  import csi_mbu_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface csi_mbu_out_if;
  import csi_mbu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PartW-1:0] real_part;
  logic signed [PartW-1:0] imag_part;
  logic [PosW-1:0]         position;
  logic                    last_entry;

  modport source (output valid, output real_part, output imag_part, output position,
                  output last_entry, input ready);
  modport sink   (input valid, input real_part, input imag_part, input position,
                  input last_entry, output ready);
endinterface

### rtl/csi_mbu_regs.sv
`timescale 1ns / 1ps

module csi_mbu_regs #(
  parameter int unsigned MAX_TONES  = 128,
  parameter int unsigned MAX_LTF    = 4,
  parameter int unsigned MAX_CHAINS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csi_mbu_pkg::ApbAddrW-1:0]   paddr,
  input  logic [csi_mbu_pkg::ApbDataW-1:0]   pwdata,
  output logic [csi_mbu_pkg::ApbDataW-1:0]   prdata,
  output logic                               pready,
  output csi_mbu_pkg::geom_t                 geom_o,
  output logic [csi_mbu_pkg::PosW-1:0]       rank_off_o [MAX_CHAINS]
);
  import csi_mbu_pkg::*;

  logic [1:0]       num_tx_q;
  logic [1:0]       num_rx_q;
  logic [2:0]       num_ltf_q;
  logic [7:0]       num_tones_q;
  logic             sel_on_q;
  logic [CodeW-1:0] code_q [NumCodes];

  logic             wr_en;
  reg_idx_e         reg_idx;

  logic [1:0]       ntx_c;
  logic [1:0]       nrx_c;
  logic [2:0]       nltf_c;
  logic [7:0]       ntones_c;
  logic [1:0]       rank_c;
  geom_t            geom_d;
  geom_t            geom_q;
  logic [PosW-1:0]  rank_off_d [MAX_CHAINS];
  logic [PosW-1:0]  rank_off_q [MAX_CHAINS];

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_tx_q    <= 2'd1;
      num_rx_q    <= 2'd1;
      num_ltf_q   <= 3'd1;
      num_tones_q <= 8'd30;
      sel_on_q    <= 1'b0;
      code_q[0]   <= 2'd0;
      code_q[1]   <= 2'd1;
      code_q[2]   <= 2'd2;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NUM_TX:     num_tx_q    <= pwdata[1:0];
        REG_NUM_RX:     num_rx_q    <= pwdata[1:0];
        REG_NUM_LTF:    num_ltf_q   <= pwdata[2:0];
        REG_NUM_TONES:  num_tones_q <= pwdata[7:0];
        REG_ANT_SEL_ON: sel_on_q    <= pwdata[0];
        REG_ANT_CODE_0: code_q[0]   <= pwdata[CodeW-1:0];
        REG_ANT_CODE_1: code_q[1]   <= pwdata[CodeW-1:0];
        REG_ANT_CODE_2: code_q[2]   <= pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_NUM_TX:     prdata = ApbDataW'(num_tx_q);
      REG_NUM_RX:     prdata = ApbDataW'(num_rx_q);
      REG_NUM_LTF:    prdata = ApbDataW'(num_ltf_q);
      REG_NUM_TONES:  prdata = ApbDataW'(num_tones_q);
      REG_ANT_SEL_ON: prdata = ApbDataW'(sel_on_q);
      REG_ANT_CODE_0: prdata = ApbDataW'(code_q[0]);
      REG_ANT_CODE_1: prdata = ApbDataW'(code_q[1]);
      REG_ANT_CODE_2: prdata = ApbDataW'(code_q[2]);
      default:        prdata = '0;
    endcase
  end

  // Zero counts act as one, oversized counts saturate.
  always_comb begin
    ntx_c = (num_tx_q == 2'd0) ? 2'd1 : num_tx_q;

    if (num_rx_q == 2'd0) begin
      nrx_c = 2'd1;
    end else if (int'(num_rx_q) > int'(MAX_CHAINS)) begin
      nrx_c = 2'(MAX_CHAINS);
    end else begin
      nrx_c = num_rx_q;
    end

    if (num_ltf_q == 3'd0) begin
      nltf_c = 3'd1;
    end else if (int'(num_ltf_q) > int'(MAX_LTF)) begin
      nltf_c = 3'(MAX_LTF);
    end else begin
      nltf_c = num_ltf_q;
    end

    if (num_tones_q == 8'd0) begin
      ntones_c = 8'd1;
    end else if (int'(num_tones_q) > int'(MAX_TONES)) begin
      ntones_c = 8'(MAX_TONES);
    end else begin
      ntones_c = num_tones_q;
    end

    geom_d.ntx        = ntx_c;
    geom_d.nrx        = nrx_c;
    geom_d.nltf       = nltf_c;
    geom_d.ntones     = ntones_c;
    geom_d.ltf_stride = PosW'(nrx_c) * PosW'(ntones_c);
    geom_d.tx_stride  = PosW'(nltf_c) * PosW'(nrx_c) * PosW'(ntones_c);
  end

  // If enabled, rank by antenna code, ties by chain index.
  always_comb begin
    rank_c = '0;
    for (int r = 0; r < int'(MAX_CHAINS); r++) begin
      rank_c = 2'(r);
      if (sel_on_q && (nrx_c > 2'd1) && (r < int'(nrx_c))) begin
        rank_c = '0;
        for (int j = 0; j < int'(MAX_CHAINS); j++) begin
          if ((j < int'(nrx_c)) &&
              ((code_q[j] < code_q[r]) || ((code_q[j] == code_q[r]) && (j < r)))) begin
            rank_c = rank_c + 2'd1;
          end
        end
      end
      rank_off_d[r] = PosW'(rank_c) * PosW'(ntones_c);
    end
  end

  always_ff @(posedge clk_i) begin
    geom_q     <= geom_d;
    rank_off_q <= rank_off_d;
  end

  assign geom_o     = geom_q;
  assign rank_off_o = rank_off_q;

endmodule

### rtl/csi_mbu_unpack.sv
`timescale 1ns / 1ps

module csi_mbu_unpack #(
  parameter int unsigned MAX_TONES  = 128,
  parameter int unsigned MAX_LTF    = 4,
  parameter int unsigned MAX_CHAINS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  csi_mbu_in_if.sink                   item_i,
  csi_mbu_out_if.source                result_o,
  input  csi_mbu_pkg::geom_t           geom_i,
  input  logic [csi_mbu_pkg::PosW-1:0] rank_off_i [MAX_CHAINS]
);
  import csi_mbu_pkg::*;

  localparam int unsigned ToneLim = (MAX_TONES > 255) ? 255 : MAX_TONES;
  localparam int unsigned LtfLim  = (MAX_LTF > 7) ? 7 : MAX_LTF;
  localparam int unsigned ToneW   = (ToneLim > 1) ? $clog2(ToneLim) : 1;
  localparam int unsigned LtfW    = (LtfLim > 1) ? $clog2(LtfLim) : 1;
  localparam int unsigned RxW     = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;

  logic             in_valid_q;
  logic [DataW-1:0] in_byte_q;
  logic             in_start_q;
  logic             adv;

  logic [BufW-1:0]  buf_q, buf_c, buf_d;
  logic [HeldW-1:0] held_q, held_c, held_d;
  logic             skip_q, skip_c, skip_d;
  logic [ToneW-1:0] tone_q, tone_c, tone_d;
  logic [RxW-1:0]   rx_q, rx_c, rx_d;
  logic [LtfW-1:0]  ltf_q, ltf_c, ltf_d;
  logic [TxW-1:0]   tx_q, tx_c, tx_d;
  logic             fin_q, fin_c, fin_d;

  logic             tx_last, ltf_last, rx_last, tone_last;
  logic             emit_c;
  logic [PartW-1:0] real_d, imag_d;
  logic [PosW-1:0]  pos_d;

  logic                    out_valid_q;
  logic signed [PartW-1:0] real_q, imag_q;
  logic [PosW-1:0]         pos_q;
  logic                    last_q;

  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_byte_q  <= item_i.data_byte;
      in_start_q <= item_i.frame_start;
    end
  end

  always_comb begin
    buf_c  = buf_q;
    held_c = held_q;
    skip_c = skip_q;
    tone_c = tone_q;
    rx_c   = rx_q;
    ltf_c  = ltf_q;
    tx_c   = tx_q;
    fin_c  = fin_q;
    if (in_start_q) begin
      buf_c  = '0;
      held_c = '0;
      skip_c = 1'b1;
      tone_c = '0;
      rx_c   = '0;
      ltf_c  = '0;
      tx_c   = '0;
      fin_c  = 1'b0;
    end

    tx_last   = (int'(tx_c) + 1) >= int'(geom_i.ntx);
    ltf_last  = (int'(ltf_c) + 1) >= int'(geom_i.nltf);
    rx_last   = (int'(rx_c) + 1) >= int'(geom_i.nrx);
    tone_last = (int'(tone_c) + 1) >= int'(geom_i.ntones);

    pos_d = PosW'(tx_c) * geom_i.tx_stride + PosW'(ltf_c) * geom_i.ltf_stride
          + rank_off_i[rx_c] + PosW'(tone_c);

    buf_d  = buf_c;
    held_d = held_c;
    skip_d = skip_c;
    tone_d = tone_c;
    rx_d   = rx_c;
    ltf_d  = ltf_c;
    tx_d   = tx_c;
    fin_d  = fin_c;
    emit_c = 1'b0;
    real_d = buf_c[PartW-1:0];
    imag_d = buf_c[2*PartW-1:PartW];

    if (!fin_c) begin
      buf_d  = buf_c | (BufW'(in_byte_q) << held_c);
      held_d = held_c + HeldW'(PartW);
      // drop the subcarrier header
      if (skip_c && (held_d >= HeldW'(HeaderBits))) begin
        buf_d  = buf_d >> HeaderBits;
        held_d = held_d - HeldW'(HeaderBits);
        skip_d = 1'b0;
      end
      if (!skip_d && (held_d >= HeldW'(EntryBits))) begin
        emit_c = 1'b1;
        real_d = buf_d[PartW-1:0];
        imag_d = buf_d[2*PartW-1:PartW];
        buf_d  = buf_d >> EntryBits;
        held_d = held_d - HeldW'(EntryBits);
        if (!tx_last) begin
          tx_d = tx_c + TxW'(1);
        end else begin
          tx_d = '0;
          if (!ltf_last) begin
            ltf_d = ltf_c + LtfW'(1);
          end else begin
            ltf_d = '0;
            if (!rx_last) begin
              rx_d = rx_c + RxW'(1);
            end else begin
              rx_d = '0;
              if (!tone_last) begin
                tone_d = tone_c + ToneW'(1);
                skip_d = 1'b1;
              end else begin
                tone_d = '0;
                fin_d  = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
      skip_q <= 1'b1;
      tone_q <= '0;
      rx_q   <= '0;
      ltf_q  <= '0;
      tx_q   <= '0;
      fin_q  <= 1'b0;
    end else if (adv) begin
      buf_q  <= buf_d;
      held_q <= held_d;
      skip_q <= skip_d;
      tone_q <= tone_d;
      rx_q   <= rx_d;
      ltf_q  <= ltf_d;
      tx_q   <= tx_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit_c;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit_c) begin
      real_q <= $signed(real_d);
      imag_q <= $signed(imag_d);
      pos_q  <= pos_d;
      last_q <= tx_last && ltf_last && rx_last && tone_last;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.real_part  = real_q;
  assign result_o.imag_part  = imag_q;
  assign result_o.position   = pos_q;
  assign result_o.last_entry = last_q;

endmodule

### rtl/csi_matrix_bit_unpacker_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// item_i    in   valid/ready        data_byte[7:0], frame_start
// result_o  out  valid/ready        real_part[7:0] s, imag_part[7:0] s, position[12:0],
//                                   last_entry
// apb       in   psel/penable       paddr[4:0], pwdata/prdata[31:0], pready tied high
//
// One byte is taken per cycle unless result_o stalls; each byte is unpacked
// in a single pass and any entry it completes is registered at result_o.
// The bit buffer and counters close one loop per cycle, which sets that rate.
// A stalled result holds in the output register; one more byte waits in the
// input register, then item_i.ready drops. Register writes reach the datapath
// via a register. Reset leaves the block waiting for a payload header.

module csi_matrix_bit_unpacker_core #(
  parameter int unsigned MAX_TONES  = 128,
  parameter int unsigned MAX_LTF    = 4,
  parameter int unsigned MAX_CHAINS = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  csi_mbu_in_if.sink                       item_i,
  csi_mbu_out_if.source                    result_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csi_mbu_pkg::ApbAddrW-1:0] paddr,
  input  logic [csi_mbu_pkg::ApbDataW-1:0] pwdata,
  output logic [csi_mbu_pkg::ApbDataW-1:0] prdata,
  output logic                             pready
);
  import csi_mbu_pkg::*;

  geom_t           geom;
  logic [PosW-1:0] rank_off [MAX_CHAINS];

  csi_mbu_regs #(
    .MAX_TONES (MAX_TONES),
    .MAX_LTF   (MAX_LTF),
    .MAX_CHAINS(MAX_CHAINS)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .geom_o    (geom),
    .rank_off_o(rank_off)
  );

  csi_mbu_unpack #(
    .MAX_TONES (MAX_TONES),
    .MAX_LTF   (MAX_LTF),
    .MAX_CHAINS(MAX_CHAINS)
  ) u_unpack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .result_o  (result_o),
    .geom_i    (geom),
    .rank_off_i(rank_off)
  );

endmodule

### rtl/csi_mbu_checker.sv
`timescale 1ns / 1ps
`include "csi_matrix_bit_unpacker_core_defines.svh"

module csi_mbu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_real_i,
  input logic [7:0]  out_imag_i,
  input logic [12:0] out_pos_i,
  input logic        out_last_i,
  input logic [31:0] prdata_i
);

  `CSI_MBU_ASSERT_IMP(a_result_needs_item, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without a byte taken two cycles before")

  `CSI_MBU_ASSERT_NXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_real_i) && $stable(out_imag_i) && $stable(out_pos_i) && $stable(out_last_i), "stalled result changed")

  `CSI_MBU_ASSERT_IMP(a_prdata_narrow, clk_i, rst_ni, 1'b1, prdata_i[31:8] == 24'd0, "register read returned bits above its width")

endmodule

bind csi_matrix_bit_unpacker_core csi_mbu_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (item_i.valid),
  .in_ready_i (item_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_real_i (result_o.real_part),
  .out_imag_i (result_o.imag_part),
  .out_pos_i  (result_o.position),
  .out_last_i (result_o.last_entry),
  .prdata_i   (prdata)
);
